/* hdl/cpu_core_pkg.sv */
// Package for the opcode-subset CPU core: payload structs, opcodes, status codes,
// state machine type and command codes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cpu_core_pkg;

  localparam int MemAddrBitsDefault = 16;
  localparam int QueueDepth = 2;

  typedef struct packed {
    logic        cmd;
    logic [15:0] addr;
    logic [7:0]  data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  t_cycles;
    logic [15:0] out_pc;
    logic [7:0]  out_a;
    logic [7:0]  out_flags;
    logic [15:0] out_bc;
    logic [15:0] out_de;
    logic [15:0] out_hl;
    logic [15:0] out_sp;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_EXECUTED = 2'd0,
    ST_MEM_WRITTEN = 2'd1,
    ST_BAD_STOP = 2'd2,
    ST_UNIMPL = 2'd3
  } status_t;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EXEC  = 1'b1;

  localparam logic [7:0] OP_NOP = 8'h00, OP_LD_BC = 8'h01, OP_ST_BC = 8'h02,
    OP_INC_BC = 8'h03, OP_INC_B = 8'h04, OP_DEC_B = 8'h05, OP_LD_B = 8'h06,
    OP_RLCA = 8'h07, OP_ST_SP = 8'h08, OP_ADD_BC = 8'h09, OP_LD_A_BC = 8'h0A,
    OP_DEC_BC = 8'h0B, OP_INC_C = 8'h0C, OP_DEC_C = 8'h0D, OP_LD_C = 8'h0E,
    OP_RRCA = 8'h0F, OP_STOP = 8'h10, OP_LD_DE = 8'h11, OP_ST_DE = 8'h12,
    OP_INC_DE = 8'h13, OP_INC_D = 8'h14, OP_DEC_D = 8'h15, OP_LD_D = 8'h16,
    OP_RLA = 8'h17, OP_JR = 8'h18, OP_ADD_DE = 8'h19, OP_LD_A_DE = 8'h1A,
    OP_DEC_DE = 8'h1B, OP_INC_E = 8'h1C;

  typedef enum logic [2:0] {
    S_IDLE, S_FETCH_OP, S_FETCH_N1, S_FETCH_N2, S_OPERAND, S_WRITE_HI, S_EXEC, S_RESULT
  } exec_state_t;

endpackage
`default_nettype wire

/* hdl/cpu_core_queue.sv */
// Two-entry transaction queue between front end and execution back end.
// Depends on cpu_core_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cpu_core_queue (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  cpu_core_pkg::in_item_t in_item,
  output logic                 out_valid,
  input  wire                  out_ready,
  output cpu_core_pkg::in_item_t out_item
);
  import cpu_core_pkg::*;

  in_item_t slots [QueueDepth];
  logic wr_ptr, rd_ptr;
  logic [1:0] count;

  assign in_ready  = (count != 2'(QueueDepth));
  assign out_valid = (count != 2'd0);
  assign out_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) slots[wr_ptr] <= in_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (in_valid && in_ready) wr_ptr <= ~wr_ptr;
      if (out_valid && out_ready) rd_ptr <= ~rd_ptr;
      unique case ({in_valid && in_ready, out_valid && out_ready})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'(QueueDepth))
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0) |-> !out_valid) else $error("empty queue shows valid");
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !(out_valid && out_ready)) |=> count == $past(count) + 2'd1)
    else $error("queue count missed a push");
endmodule
`default_nettype wire

/* hdl/cpu_core_exec.sv */
// Execution back end: register file, byte memory with one write and one read port
// and a sequencer for the memory accesses. Depends on cpu_core_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cpu_core_exec #(
  parameter int MEM_ADDR_BITS = cpu_core_pkg::MemAddrBitsDefault
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  cpu_core_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire                     out_ready,
  output cpu_core_pkg::out_item_t out_item
);
  import cpu_core_pkg::*;

  logic [7:0] mem [2**MEM_ADDR_BITS];

  exec_state_t state, state_next;
  in_item_t    cur;
  logic [7:0]  acc, reg_b, reg_c, reg_d, reg_e, reg_h, reg_l;
  logic [15:0] stack_ptr, prog_counter;
  logic        flag_z, flag_n, flag_h, flag_c;
  logic [7:0]  op, n1, n2;
  logic [7:0]  rd_data;

  // memory port controls
  logic        mem_we;
  logic [15:0] mem_waddr, mem_raddr;
  logic [7:0]  mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr[MEM_ADDR_BITS-1:0]] <= mem_wdata;
    rd_data <= mem[mem_raddr[MEM_ADDR_BITS-1:0]];
  end

  wire [15:0] bc = {reg_b, reg_c};
  wire [15:0] de = {reg_d, reg_e};
  wire [15:0] hl = {reg_h, reg_l};
  wire [15:0] a16 = {n2, n1};

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  assign in_ready = (state == S_IDLE);

  // Executes: read op, n1, n2 one per cycle, then do the store or operand read.
  always_comb begin
    state_next = state;
    mem_we    = 1'b0;
    mem_waddr = cur.addr;
    mem_wdata = cur.data;
    mem_raddr = prog_counter;
    unique case (state)
      S_IDLE: if (in_valid) state_next = (in_item.cmd == CMD_EXEC) ? S_FETCH_OP : S_EXEC;
      S_FETCH_OP: begin mem_raddr = prog_counter;         state_next = S_FETCH_N1; end
      S_FETCH_N1: begin mem_raddr = prog_counter + 16'd1; state_next = S_FETCH_N2; end
      S_FETCH_N2: begin mem_raddr = prog_counter + 16'd2; state_next = S_OPERAND;  end
      S_OPERAND: begin
        mem_raddr = (op == OP_LD_A_DE) ? de : bc;
        state_next = (op == OP_ST_SP) ? S_WRITE_HI : S_EXEC;
        if (op == OP_ST_BC || op == OP_ST_DE) begin
          mem_we = 1'b1; mem_waddr = (op == OP_ST_DE) ? de : bc; mem_wdata = acc;
        end else if (op == OP_ST_SP) begin
          // high address byte is still on the read port this cycle
          mem_we = 1'b1; mem_waddr = {rd_data, n1}; mem_wdata = stack_ptr[7:0];
        end
      end
      S_WRITE_HI: begin
        mem_we = 1'b1; mem_waddr = a16 + 16'd1; mem_wdata = stack_ptr[15:8];
        state_next = S_EXEC;
      end
      S_EXEC: begin
        mem_we = (cur.cmd == CMD_WRITE);
        state_next = S_RESULT;
      end
      S_RESULT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign out_valid = (state == S_RESULT);

  logic [1:0] st;
  logic [4:0] tc;
  logic [16:0] hl_sum;
  logic [12:0] h_sum;
  logic [15:0] add_rr;
  logic [7:0]  inc_v, dec_v, inc_src;

  always_comb begin
    add_rr  = (op == OP_ADD_DE) ? de : bc;
    hl_sum  = {1'b0, hl} + {1'b0, add_rr};
    h_sum   = {1'b0, hl[11:0]} + {1'b0, add_rr[11:0]};
    priority case (op)
      OP_INC_B, OP_DEC_B: inc_src = reg_b;
      OP_INC_C, OP_DEC_C: inc_src = reg_c;
      OP_INC_D, OP_DEC_D: inc_src = reg_d;
      default:            inc_src = reg_e;
    endcase
    inc_v = inc_src + 8'd1;
    dec_v = inc_src - 8'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= 8'h01; reg_b <= 8'h00; reg_c <= 8'h13; reg_d <= 8'h00;
      reg_e <= 8'hD8; reg_h <= 8'h01; reg_l <= 8'h4D;
      stack_ptr <= 16'hFFFE; prog_counter <= 16'h0100;
      flag_z <= 1'b1; flag_n <= 1'b0; flag_h <= 1'b0; flag_c <= 1'b0;
    end else begin
      if (state == S_IDLE && in_valid) cur <= in_item;
      if (state == S_FETCH_N1) op <= rd_data;
      if (state == S_FETCH_N2) n1 <= rd_data;
      if (state == S_OPERAND)  n2 <= rd_data;
      if (state == S_EXEC) begin
        st <= ST_EXECUTED;
        tc <= 5'd4;
        if (cur.cmd == CMD_WRITE) begin
          st <= ST_MEM_WRITTEN; tc <= 5'd0;
        end else begin
          prog_counter <= prog_counter + 16'd1;
          unique case (op)
            OP_NOP: ;
            OP_LD_BC: begin reg_c <= n1; reg_b <= n2; prog_counter <= prog_counter + 16'd3;
              tc <= 5'd12; end
            OP_LD_DE: begin reg_e <= n1; reg_d <= n2; prog_counter <= prog_counter + 16'd3;
              tc <= 5'd12; end
            OP_ST_BC, OP_ST_DE: tc <= 5'd8;
            OP_INC_BC: begin {reg_b, reg_c} <= bc + 16'd1; tc <= 5'd8; end
            OP_DEC_BC: begin {reg_b, reg_c} <= bc - 16'd1; tc <= 5'd8; end
            OP_INC_DE: begin {reg_d, reg_e} <= de + 16'd1; tc <= 5'd8; end
            OP_DEC_DE: begin {reg_d, reg_e} <= de - 16'd1; tc <= 5'd8; end
            OP_INC_B, OP_INC_C, OP_INC_D, OP_INC_E: begin
              if (op == OP_INC_B) reg_b <= inc_v;
              if (op == OP_INC_C) reg_c <= inc_v;
              if (op == OP_INC_D) reg_d <= inc_v;
              if (op == OP_INC_E) reg_e <= inc_v;
              flag_z <= (inc_v == 8'd0); flag_n <= 1'b0; flag_h <= (inc_v[3:0] == 4'h0);
            end
            OP_DEC_B, OP_DEC_C, OP_DEC_D: begin
              if (op == OP_DEC_B) reg_b <= dec_v;
              if (op == OP_DEC_C) reg_c <= dec_v;
              if (op == OP_DEC_D) reg_d <= dec_v;
              flag_z <= (dec_v == 8'd0); flag_n <= 1'b1; flag_h <= (dec_v[3:0] == 4'hF);
            end
            OP_LD_B: begin reg_b <= n1; prog_counter <= prog_counter + 16'd2; tc <= 5'd8; end
            OP_LD_C: begin reg_c <= n1; prog_counter <= prog_counter + 16'd2; tc <= 5'd8; end
            OP_LD_D: begin reg_d <= n1; prog_counter <= prog_counter + 16'd2; tc <= 5'd8; end
            OP_RLCA, OP_RRCA, OP_RLA: begin
              flag_z <= 1'b0; flag_n <= 1'b0; flag_h <= 1'b0;
              if (op == OP_RRCA) begin
                acc <= {acc[0], acc[7:1]}; flag_c <= acc[0];
              end else begin
                acc <= {acc[6:0], (op == OP_RLA) ? flag_c : acc[7]}; flag_c <= acc[7];
              end
            end
            OP_ST_SP: begin prog_counter <= prog_counter + 16'd3; tc <= 5'd20; end
            OP_ADD_BC, OP_ADD_DE: begin
              {reg_h, reg_l} <= hl_sum[15:0];
              flag_n <= 1'b0; flag_h <= h_sum[12]; flag_c <= hl_sum[16]; tc <= 5'd8;
            end
            OP_LD_A_BC, OP_LD_A_DE: begin acc <= rd_data; tc <= 5'd8; end
            OP_STOP: begin
              if (n1 != 8'd0) begin
                st <= ST_BAD_STOP; tc <= 5'd0; prog_counter <= prog_counter;
              end else prog_counter <= prog_counter + 16'd2;
            end
            OP_JR: begin
              prog_counter <= prog_counter + 16'd2 + {{8{n1[7]}}, n1}; tc <= 5'd12;
            end
            default: begin st <= ST_UNIMPL; tc <= 5'd0; prog_counter <= prog_counter; end
          endcase
        end
      end
    end
  end

  always_comb begin
    out_item.status    = st;
    out_item.t_cycles  = tc;
    out_item.out_pc    = prog_counter;
    out_item.out_a     = acc;
    out_item.out_flags = {flag_z, flag_n, flag_h, flag_c, 4'h0};
    out_item.out_bc    = bc;
    out_item.out_de    = de;
    out_item.out_hl    = hl;
    out_item.out_sp    = stack_ptr;
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |=> (state == S_RESULT)) else $error("exec did not produce result");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped while stalled");
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.t_cycles == 5'd0 || out_item.status == ST_EXECUTED))
    else $error("error status with nonzero cycles");
endmodule
`default_nettype wire

/* hdl/cpu_core_opcode_subset_core.sv */
// A memory write transaction passes through S_IDLE, S_EXEC and S_RESULT; an
// execute transaction first fetches the opcode and two operands, then stores or loads,
// and the SP store, which writes two bytes, adds S_WRITE_HI. The back end takes a new
// transaction only from S_IDLE, after the last result has been taken.
// A two-entry queue decouples acceptance from execution. Reset (rst, synchronous):
// registers take their power-on values, PC 0x0100, queue empties; memory stays undefined.
`timescale 1ns / 1ps
`default_nettype none
module cpu_core_opcode_subset_core #(
  parameter int MEM_ADDR_BITS = cpu_core_pkg::MemAddrBitsDefault
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  cpu_core_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire                     out_ready,
  output cpu_core_pkg::out_item_t out_data
);
  import cpu_core_pkg::*;

  logic     q_valid, q_ready;
  in_item_t q_item;

  // front: hold accepted transactions until the back end is free
  cpu_core_queue u_queue (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_data),
    .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
  );

  // back: sequence memory accesses and update the register file
  cpu_core_exec #(.MEM_ADDR_BITS(MEM_ADDR_BITS)) u_exec (
    .clk(clk), .rst(rst),
    .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_data)
  );

  assert property (@(posedge clk) disable iff (rst)
    (q_valid && q_ready) |=> !q_ready) else $error("back end took two transactions");
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !q_ready) else $error("back end free while result pending");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready) |=> !out_valid) else $error("result repeated");
endmodule
`default_nettype wire
